// ===== rtl/dsp_pkg.sv =====
package dsp_pkg;

    // Default graph size
    localparam int NODES_DEF = 8;

    // Fixed field widths
    localparam int NODE_W   = 3;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 20;
    localparam int PRED_W   = 4;

    // Special codes
    localparam logic [WEIGHT_W-1:0] NO_EDGE         = 16'hFFFF;
    localparam logic [DIST_W-1:0]   DIST_INF        = 20'hFFFFF;
    localparam logic [DIST_W-1:0]   DIST_MAX_FINITE = 20'hFFFFE;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RELAX,
        ST_MARK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } dsp_state_t;

    // Verdict of the relax unit for one neighbor
    typedef struct packed {
        logic              upd;
        logic              take;
        logic [DIST_W-1:0] dist_val;
    } relax_res_t;

endpackage

// ===== rtl/dsp_if.sv =====
interface dsp_in_if import dsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
    logic                run;

    modport source (output valid, row, col, weight, run, input ready);
    modport sink (input valid, row, col, weight, run, output ready);
endinterface

interface dsp_out_if import dsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic [PRED_W-1:0] predecessor;
    logic              reachable;
    logic              last_node;

    modport source (output valid, node, distance, predecessor, reachable, last_node,
                    input ready);
    modport sink (input valid, node, distance, predecessor, reachable, last_node,
                  output ready);
endinterface

interface dsp_cfg_if import dsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] start_node;

    modport source (output valid, start_node, input ready);
    modport sink (input valid, start_node, output ready);
endinterface

// ===== rtl/dsp_wmem.sv =====
module dsp_wmem import dsp_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [$clog2(NODES*NODES)-1:0]      waddr,
    input  logic [WEIGHT_W-1:0]                 wdata,
    input  logic [$clog2(NODES*NODES)-1:0]      raddr,
    output logic [WEIGHT_W-1:0]                 rdata,
    output logic                                busy
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       clr_cnt_next;
    logic                clr_busy_reg;
    logic                clr_busy_next;
    logic [WEIGHT_W-1:0] rdata_reg;

    // Advance the clearing sweep after reset
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Write port: sweep entries to no edge, then take weight writes
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= NO_EDGE;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

// ===== rtl/dsp_tbl.sv =====
module dsp_tbl import dsp_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(NODES)-1:0]       waddr,
    input  logic [DIST_W-1:0]              wdist,
    input  logic [$clog2(NODES+1)-1:0]     wpred,
    input  logic                           wvis,
    input  logic [$clog2(NODES)-1:0]       raddr,
    output logic [DIST_W-1:0]              rdist,
    output logic [$clog2(NODES+1)-1:0]     rpred,
    output logic                           rvis
);

    localparam int PW = $clog2(NODES + 1);
    localparam int EW = DIST_W + PW + 1;

    logic [EW-1:0] mem [NODES];
    logic [EW-1:0] rdata_reg;

    // One write port per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wdist, wpred, wvis};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdist = rdata_reg[EW-1 -: DIST_W];
    assign rpred = rdata_reg[PW:1];
    assign rvis  = rdata_reg[0];

endmodule

// ===== rtl/dsp_relax.sv =====
module dsp_relax import dsp_pkg::*; (
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [DIST_W-1:0]   dist_v,
    input  logic [DIST_W-1:0]   dist_j,
    input  logic                vis_j,
    input  logic [DIST_W-1:0]   best_dist,
    output relax_res_t          res
);

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] cand;
    logic              upd;
    logic [DIST_W-1:0] new_dist;

    // Add edge to settled distance, clamp to the largest finite value
    always_comb
    begin
        sum  = {1'b0, dist_v} + (DIST_W + 1)'(weight);
        cand = (sum > {1'b0, DIST_MAX_FINITE}) ? DIST_MAX_FINITE : sum[DIST_W-1:0];
        upd  = !vis_j && (weight != NO_EDGE) && (cand < dist_j);
        new_dist = upd ? cand : dist_j;
    end

    // Track the nearest unvisited node
    always_comb
    begin
        res.upd      = upd;
        res.dist_val = new_dist;
        res.take     = !vis_j && (new_dist < best_dist);
    end

endmodule

// ===== rtl/dense_shortest_path_tree.sv =====
// Channel  | Dir | Payload                                         | Handshake
// ---------+-----+-------------------------------------------------+-------------
// update   | in  | row, col, weight, run                           | valid/ready
// result   | out | node, distance, predecessor, reachable, last    | valid/ready
// cfg      | in  | start_node                                      | valid/ready
//
// After reset the weight matrix is swept to no edge; update holds ready low
// meanwhile (cfg is always ready). A run item resets the table, then relaxes the
// neighbors of each settled node (up to NODES nodes) and marks the next one
// settled, through the single table read port feeding one relax unit, then
// emits each result through the read, load and wait states, holding on any
// stall on result. No new item is taken until the last result of a run is
// accepted.
module dense_shortest_path_tree import dsp_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dsp_in_if.sink        update,
    dsp_out_if.source     result,
    dsp_cfg_if.sink       cfg
);

    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int PW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES * NODES);

    dsp_state_t state_reg;
    dsp_state_t state_next;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [NW-1:0]     v_reg;
    logic [NW-1:0]     v_next;
    logic [DIST_W-1:0] dv_reg;
    logic [DIST_W-1:0] dv_next;
    logic [NODE_W-1:0] start_reg;
    logic              stg_valid_reg;
    logic              stg_valid_next;
    logic [NW-1:0]     stg_j_reg;
    logic [NW-1:0]     stg_j_next;
    logic              best_found_reg;
    logic              best_found_next;
    logic [NW-1:0]     best_idx_reg;
    logic [NW-1:0]     best_idx_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;
    logic [PW-1:0]     best_pred_reg;
    logic [PW-1:0]     best_pred_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [NODE_W-1:0] out_node_reg;
    logic [NODE_W-1:0] out_node_next;
    logic [DIST_W-1:0] out_dist_reg;
    logic [DIST_W-1:0] out_dist_next;
    logic [PRED_W-1:0] out_pred_reg;
    logic [PRED_W-1:0] out_pred_next;
    logic              out_reach_reg;
    logic              out_reach_next;
    logic              out_last_reg;
    logic              out_last_next;

    // Index conversions between field widths and internal widths
    logic [NODE_W+NW-1:0] row_wide;
    logic [NODE_W+NW-1:0] col_wide;
    logic [NODE_W+NW-1:0] start_wide;
    logic [NW-1:0]        row_idx;
    logic [NW-1:0]        col_idx;
    logic [NW-1:0]        start_idx;
    logic                 wr_in_range;
    logic                 start_ok;
    logic [NW-1:0]        cnt_idx;
    logic [NW+NODE_W-1:0] node_wide;
    logic [PW+PRED_W-1:0] pred_wide;
    logic                 out_reach;
    logic [PW-1:0]        out_pred_int;

    // Memory and unit hookup
    logic                 mat_we;
    logic [AW-1:0]        mat_waddr;
    logic [AW-1:0]        mat_raddr;
    logic [WEIGHT_W-1:0]  mat_rdata;
    logic                 mat_busy;
    logic                 tbl_we;
    logic [NW-1:0]        tbl_waddr;
    logic [DIST_W-1:0]    tbl_wdist;
    logic [PW-1:0]        tbl_wpred;
    logic                 tbl_wvis;
    logic [DIST_W-1:0]    tbl_rdist;
    logic [PW-1:0]        tbl_rpred;
    logic                 tbl_rvis;
    relax_res_t           rlx;

    logic in_fire;
    logic out_fire;

    assign in_fire  = update.valid && update.ready;
    assign out_fire = result.valid && result.ready;

    assign row_wide    = {{NW{1'b0}}, update.row};
    assign col_wide    = {{NW{1'b0}}, update.col};
    assign start_wide  = {{NW{1'b0}}, start_reg};
    assign row_idx     = row_wide[NW-1:0];
    assign col_idx     = col_wide[NW-1:0];
    assign start_idx   = start_wide[NW-1:0];
    assign wr_in_range = (32'(update.row) < NODES) && (32'(update.col) < NODES);
    assign start_ok    = 32'(start_reg) < NODES;
    assign cnt_idx     = cnt_reg[NW-1:0];

    // Weight matrix write and read addresses
    assign mat_we    = in_fire && wr_in_range;
    assign mat_waddr = AW'(row_idx) * AW'(NODES) + AW'(col_idx);
    assign mat_raddr = AW'(v_reg) * AW'(NODES) + AW'(cnt_idx);

    dsp_wmem #(
        .NODES (NODES)
    ) u_wmem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (update.weight),
        .raddr (mat_raddr),
        .rdata (mat_rdata),
        .busy  (mat_busy)
    );

    dsp_tbl #(
        .NODES (NODES)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdist (tbl_wdist),
        .wpred (tbl_wpred),
        .wvis  (tbl_wvis),
        .raddr (cnt_idx),
        .rdist (tbl_rdist),
        .rpred (tbl_rpred),
        .rvis  (tbl_rvis)
    );

    dsp_relax u_relax (
        .weight    (mat_rdata),
        .dist_v    (dv_reg),
        .dist_j    (tbl_rdist),
        .vis_j     (tbl_rvis),
        .best_dist (best_dist_reg),
        .res       (rlx)
    );

    // Result fields from the table read
    assign out_reach    = tbl_rdist != DIST_INF;
    assign out_pred_int = out_reach ? tbl_rpred : PW'(NODES);
    assign node_wide    = {{NODE_W{1'b0}}, cnt_idx};
    assign pred_wide    = {{PRED_W{1'b0}}, out_pred_int};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && update.run)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == CW'(NODES - 1))
                begin
                    state_next = start_ok ? ST_RELAX : ST_EMIT_RD;
                end
            end
            ST_RELAX:
            begin
                if (stg_valid_reg && (stg_j_reg == NW'(NODES - 1)))
                begin
                    state_next = (best_found_reg || rlx.take) ? ST_MARK : ST_EMIT_RD;
                end
            end
            ST_MARK:
            begin
                state_next = ST_RELAX;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cnt_next        = cnt_reg;
        v_next          = v_reg;
        dv_next         = dv_reg;
        stg_valid_next  = 1'b0;
        stg_j_next      = stg_j_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_pred_next  = best_pred_reg;
        out_valid_next  = out_valid_reg;
        out_node_next   = out_node_reg;
        out_dist_next   = out_dist_reg;
        out_pred_next   = out_pred_reg;
        out_reach_next  = out_reach_reg;
        out_last_next   = out_last_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = cnt_idx;
        tbl_wdist       = DIST_INF;
        tbl_wpred       = PW'(NODES);
        tbl_wvis        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
            end
            ST_INIT:
            begin
                // Reset each entry, seed the start node
                tbl_we = 1'b1;
                if (start_ok && (cnt_idx == start_idx))
                begin
                    tbl_wdist = '0;
                    tbl_wvis  = 1'b1;
                end
                cnt_next        = cnt_reg + CW'(1);
                v_next          = start_idx;
                dv_next         = '0;
                best_found_next = 1'b0;
                best_dist_next  = DIST_INF;
                if (cnt_reg == CW'(NODES - 1))
                begin
                    cnt_next = '0;
                end
            end
            ST_RELAX:
            begin
                // Issue reads for the next neighbor
                if (cnt_reg < CW'(NODES))
                begin
                    stg_valid_next = 1'b1;
                    stg_j_next     = cnt_idx;
                    cnt_next       = cnt_reg + CW'(1);
                end
                // Relax the neighbor whose data came back
                if (stg_valid_reg)
                begin
                    tbl_we    = rlx.upd;
                    tbl_waddr = stg_j_reg;
                    tbl_wdist = rlx.dist_val;
                    tbl_wpred = PW'(v_reg);
                    tbl_wvis  = 1'b0;
                    if (rlx.take)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = stg_j_reg;
                        best_dist_next  = rlx.dist_val;
                        best_pred_next  = rlx.upd ? PW'(v_reg) : tbl_rpred;
                    end
                    if (stg_j_reg == NW'(NODES - 1))
                    begin
                        cnt_next = '0;
                    end
                end
            end
            ST_MARK:
            begin
                // Settle the chosen node and make it the next source
                tbl_we          = 1'b1;
                tbl_waddr       = best_idx_reg;
                tbl_wdist       = best_dist_reg;
                tbl_wpred       = best_pred_reg;
                tbl_wvis        = 1'b1;
                v_next          = best_idx_reg;
                dv_next         = best_dist_reg;
                best_found_next = 1'b0;
                best_dist_next  = DIST_INF;
                cnt_next        = '0;
            end
            ST_EMIT_RD:
            begin
            end
            ST_EMIT_LD:
            begin
                // Load the output register from the table
                out_valid_next = 1'b1;
                out_node_next  = node_wide[NODE_W-1:0];
                out_dist_next  = tbl_rdist;
                out_pred_next  = pred_wide[PRED_W-1:0];
                out_reach_next = out_reach;
                out_last_next  = cnt_reg == CW'(NODES - 1);
            end
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    cnt_next       = cnt_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            stg_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            stg_valid_reg  <= stg_valid_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                start_reg <= cfg.start_node;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        dv_reg        <= dv_next;
        stg_j_reg     <= stg_j_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_pred_reg <= best_pred_next;
        out_node_reg  <= out_node_next;
        out_dist_reg  <= out_dist_next;
        out_pred_reg  <= out_pred_next;
        out_reach_reg <= out_reach_next;
        out_last_reg  <= out_last_next;
    end

    // Port drive
    assign update.ready       = (state_reg == ST_IDLE) && !mat_busy;
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.node        = out_node_reg;
    assign result.distance    = out_dist_reg;
    assign result.predecessor = out_pred_reg;
    assign result.reachable   = out_reach_reg;
    assign result.last_node   = out_last_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dsp_pkg::*;

    localparam int CLK_NS      = 12;
    localparam int RESET_CYC   = 12;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE_CYC  = 200;
    localparam int DRAIN_LIMIT = 200000;
    localparam int PHASE_ITEMS = 85;
    localparam int DIRECTED_N  = 18;

    localparam logic [WEIGHT_W-1:0] HEAVY_W = NO_EDGE - 16'd1;

    // Pacing of sender and receiver
    typedef enum {
        PACE_NONE,
        PACE_SRC,
        PACE_SNK,
        PACE_BOTH
    } pace_t;

    // How the expected rows of a run item are obtained
    typedef enum {
        CHK_PREDICT,
        CHK_ROOT_ONLY,
        CHK_CHAIN
    } row_check_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic [PRED_W-1:0] pred;
        logic              reach;
        logic              last;
    } tree_row_t;

    typedef struct {
        logic [NODE_W-1:0]   row;
        logic [NODE_W-1:0]   col;
        logic [WEIGHT_W-1:0] weight;
        logic                run;
        row_check_t          check;
    } update_step_t;

    logic clk;
    logic rst_n;

    dsp_in_if  update_ch ();
    dsp_out_if result_ch ();
    dsp_cfg_if cfg_ch ();

    dense_shortest_path_tree #(
        .NODES (NODES_DEF)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Local copy of the graph and the start register
    logic [WEIGHT_W-1:0] edge_w [NODES_DEF][NODES_DEF];
    logic [NODE_W-1:0]   root_node;

    tree_row_t tree_rows_due [$];
    int        fail_count;
    pace_t     pace;
    int        hold_requests;

    // Edge writes, the chain of heaviest edges, ties and diagonal entries
    update_step_t directed_steps [DIRECTED_N] = '{
        '{3'd0, 3'd0, 16'd5,   1'b1, CHK_ROOT_ONLY},
        '{3'd0, 3'd1, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd1, 3'd2, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd2, 3'd3, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd3, 3'd4, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd4, 3'd5, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd5, 3'd6, HEAVY_W, 1'b0, CHK_PREDICT},
        '{3'd6, 3'd7, HEAVY_W, 1'b1, CHK_CHAIN},
        '{3'd0, 3'd7, 16'd0,   1'b1, CHK_PREDICT},
        '{3'd0, 3'd2, HEAVY_W, 1'b1, CHK_PREDICT},
        '{3'd7, 3'd1, HEAVY_W, 1'b1, CHK_PREDICT},
        '{3'd2, 3'd2, 16'd0,   1'b1, CHK_PREDICT},
        '{3'd1, 3'd0, 16'd1,   1'b0, CHK_PREDICT},
        '{3'd0, 3'd1, NO_EDGE, 1'b1, CHK_PREDICT},
        '{3'd7, 3'd0, NO_EDGE, 1'b0, CHK_PREDICT},
        '{3'd5, 3'd0, 16'd0,   1'b1, CHK_PREDICT},
        '{3'd7, 3'd7, NO_EDGE, 1'b1, CHK_PREDICT},
        '{3'd3, 3'd5, 16'h1234, 1'b1, CHK_PREDICT}
    };

    // Run the dense search on the local graph and queue one row per node
    function automatic void grow_path_tree();
        logic [DIST_W-1:0] dist_tbl [NODES_DEF];
        logic              seen [NODES_DEF];
        logic [PRED_W-1:0] pred [NODES_DEF];
        logic [DIST_W:0]   cand;
        logic [DIST_W-1:0] best_d;
        tree_row_t         r;
        int                v;

        for (int j = 0; j < NODES_DEF; j++)
        begin
            dist_tbl[j] = DIST_INF;
            seen[j] = 1'b0;
            pred[j] = PRED_W'(NODES_DEF);
        end
        v = -1;
        if (root_node < NODES_DEF)
        begin
            v = root_node;
            seen[v] = 1'b1;
            dist_tbl[v] = '0;
        end
        while (v >= 0)
        begin
            // Relax the outgoing edges of the node just settled
            for (int j = 0; j < NODES_DEF; j++)
            begin
                if (!seen[j] && edge_w[v][j] != NO_EDGE)
                begin
                    cand = dist_tbl[v] + edge_w[v][j];
                    if (cand > DIST_MAX_FINITE)
                        cand = {1'b0, DIST_MAX_FINITE};
                    if (cand < dist_tbl[j])
                    begin
                        dist_tbl[j] = cand[DIST_W-1:0];
                        pred[j] = PRED_W'(v);
                    end
                end
            end
            // Settle the closest unvisited node, lowest index on ties
            v = -1;
            best_d = DIST_INF;
            for (int i = 0; i < NODES_DEF; i++)
            begin
                if (!seen[i] && dist_tbl[i] < best_d)
                begin
                    best_d = dist_tbl[i];
                    v = i;
                end
            end
            if (v >= 0)
                seen[v] = 1'b1;
        end
        for (int i = 0; i < NODES_DEF; i++)
        begin
            r.node     = NODE_W'(i);
            r.distance = dist_tbl[i];
            r.reach    = (dist_tbl[i] != DIST_INF);
            r.pred     = r.reach ? pred[i] : PRED_W'(NODES_DEF);
            r.last     = (i == NODES_DEF - 1);
            tree_rows_due.push_back(r);
        end
    endfunction

    // Queue rows whose values are known by inspection
    function automatic void queue_typed_rows(input row_check_t check);
        tree_row_t r;

        for (int i = 0; i < NODES_DEF; i++)
        begin
            r.node = NODE_W'(i);
            r.last = (i == NODES_DEF - 1);
            if (check == CHK_ROOT_ONLY)
            begin
                r.reach    = (i == root_node);
                r.distance = r.reach ? '0 : DIST_INF;
                r.pred     = PRED_W'(NODES_DEF);
            end
            else
            begin
                r.reach    = 1'b1;
                r.distance = DIST_W'(i * HEAVY_W);
                r.pred     = (i == 0) ? PRED_W'(NODES_DEF) : PRED_W'(i - 1);
            end
            tree_rows_due.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int node,
                                        input longint expv, input longint actv);
        if (expv != actv)
        begin
            $display("%0t: node %0d %s mismatch: expected %0d, actual %0d",
                     $time, node, name, expv, actv);
            fail_count++;
        end
    endfunction

    // No edge, light or extreme weights, some fully random
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int sel;

        sel = $urandom_range(9);
        if (sel <= 2)
            return NO_EDGE;
        if (sel <= 5)
            return WEIGHT_W'($urandom_range(20));
        if (sel == 6)
            return '0;
        if (sel == 7)
            return HEAVY_W;
        return WEIGHT_W'($urandom);
    endfunction

    // Offer one item and apply it to the local graph once taken
    task automatic send_update(input logic [NODE_W-1:0] r, input logic [NODE_W-1:0] c,
                               input logic [WEIGHT_W-1:0] w, input logic run,
                               input row_check_t check);
        int gap_pct;

        gap_pct = (pace == PACE_SRC) ? 80 : (pace == PACE_BOTH) ? 10 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            update_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        update_ch.valid  <= 1'b1;
        update_ch.row    <= r;
        update_ch.col    <= c;
        update_ch.weight <= w;
        update_ch.run    <= run;
        do
            @(posedge clk);
        while (!update_ch.ready);
        edge_w[r][c] = w;
        if (run)
        begin
            if (check == CHK_PREDICT)
                grow_path_tree();
            else
                queue_typed_rows(check);
        end
    endtask

    // Drop valid, wait for every queued row, then let the block go quiet
    task automatic drain(input int settle);
        int waited;

        update_ch.valid <= 1'b0;
        waited = 0;
        while (tree_rows_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_start(input logic [NODE_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.start_node <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        root_node = value;
    endtask

    // A burst of edge writes closed by a run, or now and then loose noise
    task automatic random_burst(output int sent);
        int n;

        n = $urandom_range(1, 12);
        if ($urandom_range(7) == 0)
        begin
            for (int k = 0; k < n; k++)
                send_update(NODE_W'($urandom), NODE_W'($urandom), pick_weight(),
                            ($urandom_range(5) == 0), CHK_PREDICT);
            sent = n;
        end
        else
        begin
            for (int k = 0; k < n; k++)
                send_update(NODE_W'($urandom), NODE_W'($urandom), pick_weight(),
                            1'b0, CHK_PREDICT);
            send_update(NODE_W'($urandom), NODE_W'($urandom), pick_weight(),
                        1'b1, CHK_PREDICT);
            sent = n + 1;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_NS / 2.0) clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #(CLK_NS * 400000);
        $display("** dense_shortest_path_tree: FAILED **");
        $finish;
    end

    // Result side: check each taken item, then choose ready for the next edge
    always @(posedge clk)
    begin : result_side
        static int hold_left  = 0;
        static int holds_done = 0;
        tree_row_t want;
        int        stall_pct;

        if (result_ch.valid && result_ch.ready)
        begin
            if (tree_rows_due.size() == 0)
            begin
                $display("%0t: unexpected result: node %0d distance %0d pred %0d",
                         $time, result_ch.node, result_ch.distance,
                         result_ch.predecessor);
                fail_count++;
            end
            else
            begin
                want = tree_rows_due.pop_front();
                check_field("node", want.node, want.node, result_ch.node);
                check_field("distance", want.node, want.distance, result_ch.distance);
                check_field("predecessor", want.node, want.pred, result_ch.predecessor);
                check_field("reachable", want.node, want.reach, result_ch.reachable);
                check_field("last_node", want.node, want.last, result_ch.last_node);
            end
        end

        stall_pct = (pace == PACE_SNK) ? 80 : (pace == PACE_BOTH) ? 10 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done++;
            hold_left = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stimulus
    initial
    begin : stimulus
        pace_t       phase_pace [4] = '{PACE_NONE, PACE_SRC, PACE_SNK, PACE_BOTH};
        logic [2:0]  phase_root [4];
        int          sent;
        int          phase_count;

        fail_count    = 0;
        hold_requests = 0;
        pace          = PACE_NONE;
        root_node     = '0;
        for (int i = 0; i < NODES_DEF; i++)
            for (int j = 0; j < NODES_DEF; j++)
                edge_w[i][j] = NO_EDGE;

        rst_n             <= 1'b0;
        update_ch.valid   <= 1'b0;
        update_ch.row     <= '0;
        update_ch.col     <= '0;
        update_ch.weight  <= '0;
        update_ch.run     <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.start_node <= '0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items with start at its reset value
        foreach (directed_steps[k])
            send_update(directed_steps[k].row, directed_steps[k].col,
                        directed_steps[k].weight, directed_steps[k].run,
                        directed_steps[k].check);
        drain(SETTLE_CYC);

        // Random phases, each with its own pacing and start node
        phase_root[0] = 3'd7;
        phase_root[1] = 3'd0;
        phase_root[2] = 3'd5;
        phase_root[3] = NODE_W'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            pace = phase_pace[p];
            write_start(phase_root[p]);
            // Hold results off for a long stretch so the block backs up
            if (p == 0)
                hold_requests++;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                random_burst(sent);
                phase_count += sent;
            end
            drain(SETTLE_CYC);
        end

        if (tree_rows_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     tree_rows_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** dense_shortest_path_tree: PASSED **");
        else
            $display("** dense_shortest_path_tree: FAILED **");
        $finish;
    end

endmodule
